@@ rtl/qbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_pkg: shared types and constants of the quadratic B-spline segmenter
// Coordinate width, blend weights and the fixed-point constants for the
// divide by the weight scale.
// ----------------------------------------------------------------------------
package qbs_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SCALE       = 1000;
  localparam int HALF_SCALE  = SCALE / 2;
  localparam int STEPS       = 10;
  localparam int STEP_BITS   = $clog2(STEPS);
  localparam int MID_STEP    = STEPS / 2;
  localparam int WB_PEAK     = (3 * SCALE) / 4;
  localparam int WT_UNIT     = SCALE / (2 * STEPS * STEPS);
  localparam int WEIGHT_BITS = $clog2(WB_PEAK + 1);

  // Product, sum and magnitude widths of the blend datapath
  localparam int PROD_BITS   = COORD_BITS + WEIGHT_BITS;
  localparam int SUM_BITS    = PROD_BITS + 2;
  localparam int MAG_BITS    = SUM_BITS - 1;
  // 2^MAG_BITS / SCALE stays below 2^(MAG_BITS - 9) as SCALE exceeds 512
  localparam int RECIP_BITS  = MAG_BITS - 9;
  localparam int QUO_BITS    = RECIP_BITS;
  localparam int RPROD_BITS  = MAG_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'((64'd1 << MAG_BITS) / SCALE);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] from_x;
    logic signed [COORD_BITS-1:0] from_y;
    logic signed [COORD_BITS-1:0] to_x;
    logic signed [COORD_BITS-1:0] to_y;
    logic                         last_segment;
  } segment_t;

  typedef struct packed {
    logic first_seg;
    logic last_segment;
  } side_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] wa;
    logic [WEIGHT_BITS-1:0] wb;
    logic [WEIGHT_BITS-1:0] wc;
  } weights_t;

  typedef enum logic [1:0] {
    HELD_NONE = 2'd0,
    HELD_ONE  = 2'd1,
    HELD_MANY = 2'd2
  } held_t;

  // Blend weights of segment j; they sum to SCALE for every valid step
  function automatic weights_t seg_weights(input logic [STEP_BITS-1:0] j);
    int       k;
    weights_t w;
    k    = int'(j);
    w.wc = WEIGHT_BITS'(WT_UNIT * k * k);
    w.wb = WEIGHT_BITS'(WB_PEAK - 2 * WT_UNIT * (k - MID_STEP) * (k - MID_STEP));
    w.wa = WEIGHT_BITS'(WT_UNIT * (k - STEPS) * (k - STEPS));
    return w;
  endfunction

endpackage

@@ rtl/qbs_blend.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_blend: weighted blend of three coordinates, divided by the scale
// Three register stages: products, rounded sum as sign and magnitude,
// reciprocal quotient; the final correction and sign are combinational.
// ----------------------------------------------------------------------------
module qbs_blend (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [qbs_pkg::STEP_BITS-1:0]         step,
  input  logic signed [qbs_pkg::COORD_BITS-1:0] a,
  input  logic signed [qbs_pkg::COORD_BITS-1:0] b,
  input  logic signed [qbs_pkg::COORD_BITS-1:0] c,
  output logic signed [qbs_pkg::COORD_BITS-1:0] curve
);
  import qbs_pkg::*;

  weights_t                     w;
  logic signed [PROD_BITS-1:0]  prod_a;
  logic signed [PROD_BITS-1:0]  prod_b;
  logic signed [PROD_BITS-1:0]  prod_c;
  logic signed [SUM_BITS-1:0]   sum;
  logic [MAG_BITS-1:0]          mag;
  logic                         neg;
  logic [MAG_BITS-1:0]          mag_q;
  logic                         neg_q;
  logic [RPROD_BITS-1:0]        recip_prod;
  logic [QUO_BITS-1:0]          quo;
  logic [MAG_BITS-1:0]          rem;
  logic [QUO_BITS-1:0]          quo_fix;

  assign w = seg_weights(step);

  assign sum = SUM_BITS'(prod_a) + SUM_BITS'(prod_b) + SUM_BITS'(prod_c)
             + SUM_BITS'(HALF_SCALE);

  assign recip_prod = RPROD_BITS'(mag) * RPROD_BITS'(RECIP);

  // Quotient from the reciprocal is low by at most one
  assign rem     = mag_q - MAG_BITS'(quo) * MAG_BITS'(SCALE);
  assign quo_fix = quo + QUO_BITS'(rem >= MAG_BITS'(SCALE));
  assign curve   = neg_q ? -COORD_BITS'(quo_fix) : COORD_BITS'(quo_fix);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= PROD_BITS'(a) * PROD_BITS'($signed({1'b0, w.wa}));
      prod_b <= PROD_BITS'(b) * PROD_BITS'($signed({1'b0, w.wb}));
      prod_c <= PROD_BITS'(c) * PROD_BITS'($signed({1'b0, w.wc}));
      neg    <= sum[SUM_BITS-1];
      mag    <= sum[SUM_BITS-1] ? MAG_BITS'(-sum) : MAG_BITS'(sum);
      neg_q  <= neg;
      mag_q  <= mag;
      quo    <= recip_prod[MAG_BITS +: QUO_BITS];
    end
  end

endmodule

@@ rtl/quadratic_bspline_segmenter_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one segment per cycle while the sequencer is active, unless
// seg_stall holds the output; the rate is set by the window sequencer issuing
// one step a cycle. A point yields ten segments, the closing point of a stroke
// of two or more points twenty, and an opening point that is not the last none.
// Reset: synchronous, active high; empties the pipeline and closes any stroke.
// ----------------------------------------------------------------------------
// quadratic_bspline_segmenter_unit: quadratic B-spline stroke segmenter
// Turns the control points of a stroke into line segments, ten per window of
// three consecutive points, with the first and last point doubled.
// ----------------------------------------------------------------------------
module quadratic_bspline_segmenter_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              point_valid,
  output logic              point_stall,
  input  qbs_pkg::point_t   point,
  output logic              seg_valid,
  input  logic              seg_stall,
  output qbs_pkg::segment_t seg
);
  import qbs_pkg::*;

  // Input register: takes an item while the sequencer is still busy
  point_t                       ir_item;
  logic                         ir_valid;
  logic                         take;

  // Window sequencer
  logic                         active;
  logic                         tail;
  logic                         closes;
  logic                         first;
  logic [STEP_BITS-1:0]         step;
  logic                         last_step;
  logic                         seq_free;
  held_t                        points_held;
  logic signed [COORD_BITS-1:0] older_x, older_y;
  logic signed [COORD_BITS-1:0] newer_x, newer_y;
  logic signed [COORD_BITS-1:0] win_ax, win_ay;
  logic signed [COORD_BITS-1:0] win_bx, win_by;
  logic signed [COORD_BITS-1:0] win_cx, win_cy;
  logic signed [COORD_BITS-1:0] start_x, start_y;

  // Pipeline
  logic                         en;
  side_t                        issue_side;
  side_t                        p_side, n_side, q_side;
  logic                         p_valid, n_valid, q_valid;
  logic signed [COORD_BITS-1:0] curve_x, curve_y;
  segment_t                     seg_next;

  // Whole pipeline advances unless a finished segment waits on the output
  assign en = !seg_valid || !seg_stall;

  assign last_step = (step == STEP_BITS'(STEPS - 1));
  // Free when idle or once the final step of the final pending window issues
  assign seq_free  = !active || (last_step && !tail);
  assign take      = ir_valid && en && seq_free;

  assign point_stall = ir_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (point_valid && !point_stall) begin
      ir_valid <= 1'b1;
    end else if (take) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (point_valid && !point_stall) begin
      ir_item <= point;
    end
  end

  // Sequencer: walk the steps of the current window, then either slide to the
  // closing window (b, c, c) or hand over to the next point
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      tail        <= 1'b0;
      closes      <= 1'b0;
      first       <= 1'b0;
      step        <= '0;
      points_held <= HELD_NONE;
    end else if (en) begin
      if (active) begin
        if (!last_step) begin
          step <= step + STEP_BITS'(1);
        end else if (tail) begin
          win_ax <= win_bx;
          win_ay <= win_by;
          win_bx <= win_cx;
          win_by <= win_cy;
          closes <= 1'b1;
          tail   <= 1'b0;
          first  <= 1'b0;
          step   <= '0;
        end else begin
          active <= 1'b0;
        end
      end
      if (take) begin
        if (points_held == HELD_NONE) begin
          // Opening point: the pen starts here
          older_x <= ir_item.point_x;
          older_y <= ir_item.point_y;
          newer_x <= ir_item.point_x;
          newer_y <= ir_item.point_y;
          start_x <= ir_item.point_x;
          start_y <= ir_item.point_y;
          if (ir_item.last_point) begin
            // Single-point stroke: one window of the point thrice
            active <= 1'b1;
            win_ax <= ir_item.point_x;
            win_ay <= ir_item.point_y;
            win_bx <= ir_item.point_x;
            win_by <= ir_item.point_y;
            win_cx <= ir_item.point_x;
            win_cy <= ir_item.point_y;
            closes <= 1'b1;
            tail   <= 1'b0;
            first  <= 1'b1;
            step   <= '0;
          end else begin
            active      <= 1'b0;
            points_held <= HELD_ONE;
          end
        end else begin
          active      <= 1'b1;
          win_ax      <= older_x;
          win_ay      <= older_y;
          win_bx      <= newer_x;
          win_by      <= newer_y;
          win_cx      <= ir_item.point_x;
          win_cy      <= ir_item.point_y;
          closes      <= 1'b0;
          tail        <= ir_item.last_point;
          first       <= (points_held == HELD_ONE);
          step        <= '0;
          older_x     <= newer_x;
          older_y     <= newer_y;
          newer_x     <= ir_item.point_x;
          newer_y     <= ir_item.point_y;
          points_held <= ir_item.last_point ? HELD_NONE : HELD_MANY;
        end
      end
    end
  end

  // Tag the first step of a stroke (from the start point) and the last one
  assign issue_side.first_seg    = first && (step == '0);
  assign issue_side.last_segment = closes && last_step;

  qbs_blend u_blend_x (
    .clk   (clk),
    .en    (en),
    .step  (step),
    .a     (win_ax),
    .b     (win_bx),
    .c     (win_cx),
    .curve (curve_x)
  );

  qbs_blend u_blend_y (
    .clk   (clk),
    .en    (en),
    .step  (step),
    .a     (win_ay),
    .b     (win_by),
    .c     (win_cy),
    .curve (curve_y)
  );

  // The start point register is rewritten only when a new point is taken, at
  // least nine steps after any first step issued, so it is stable by then.
  // Otherwise the pen is the end of the segment last loaded into seg.
  always_comb begin
    seg_next.to_x         = curve_x;
    seg_next.to_y         = curve_y;
    seg_next.from_x       = q_side.first_seg ? start_x : seg.to_x;
    seg_next.from_y       = q_side.first_seg ? start_y : seg.to_y;
    seg_next.last_segment = q_side.last_segment;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      n_valid   <= 1'b0;
      q_valid   <= 1'b0;
      seg_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= active;
      n_valid   <= p_valid;
      q_valid   <= n_valid;
      seg_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= issue_side;
      n_side <= p_side;
      q_side <= n_side;
      if (q_valid) begin
        seg <= seg_next;
      end
    end
  end

endmodule

@@ rtl/qbs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_checker: port-level checks of the segmenter
// Watches both channels and checks stall holding, segment chaining and start-up behaviour.
// ----------------------------------------------------------------------------
module qbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              point_valid,
  input logic              point_stall,
  input logic              seg_valid,
  input logic              seg_stall,
  input qbs_pkg::segment_t seg
);
  import qbs_pkg::*;

  logic                         seen_point;
  logic                         seen_seg;
  logic                         prev_last;
  logic signed [COORD_BITS-1:0] prev_to_x;
  logic signed [COORD_BITS-1:0] prev_to_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_point <= 1'b0;
      seen_seg   <= 1'b0;
      prev_last  <= 1'b0;
    end else begin
      if (point_valid && !point_stall) begin
        seen_point <= 1'b1;
      end
      if (seg_valid && !seg_stall) begin
        seen_seg  <= 1'b1;
        prev_last <= seg.last_segment;
        prev_to_x <= seg.to_x;
        prev_to_y <= seg.to_y;
      end
    end
  end

  // Hold a stalled segment
  assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("stalled segment changed or dropped");

  // Chain each segment from the end of the one before, inside a stroke
  assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_stall && seen_seg && !prev_last |->
      seg.from_x == prev_to_x && seg.from_y == prev_to_y)
    else $error("segment does not start at the pen position");

  // No segment before any point has been taken
  assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> seen_point)
    else $error("segment without any accepted point");

  // Input side free straight after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !point_stall)
    else $error("point channel stalled right after reset");

endmodule

bind quadratic_bspline_segmenter_unit qbs_checker u_qbs_checker (.*);

@@ sim/quadratic_bspline_segmenter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bspline_segmenter_unit_test: stroke segmenter testbench
// Feeds strokes of control points, directed corners first and then random
// strokes under four idling mixes. Each accepted point is run through an
// in-bench spline predictor, and every segment leaving the block is checked
// field by field against the oldest predicted segment.
// ----------------------------------------------------------------------------
module quadratic_bspline_segmenter_unit_test;
  import qbs_pkg::*;

  localparam int  SEGS_PER_WINDOW = 10;
  localparam int  WEIGHT_SCALE    = 1000;
  localparam int  DRAIN_CYCLES    = 20;      // lets any surplus segment show up after the queue empties
  localparam int  CYCLE_LIMIT     = 500000;  // far beyond the slowest clean run
  localparam int  REPORT_CAP      = 40;      // keep the log short on a bad build

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic     clk         = 1'b0;
  logic     rst         = 1'b1;
  logic     point_valid = 1'b0;
  logic     point_stall;
  point_t   point       = '0;
  logic     seg_valid;
  logic     seg_stall   = 1'b0;
  segment_t seg;

  quadratic_bspline_segmenter_unit uut (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .seg_valid   (seg_valid),
    .seg_stall   (seg_stall),
    .seg         (seg)
  );

  always #5 clk = ~clk;

  // Predicted segments, oldest first
  segment_t pending_segments[$];

  // Predictor state: the pending window, the pen and the stroke progress
  int    older_x, older_y, newer_x, newer_y, pen_x, pen_y;
  held_t stroke_held;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int failures        = 0;
  int strokes_sent    = 0;
  int points_sent     = 0;
  int segments_seen   = 0;
  int cycle_count     = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Curve coordinate of step j over window (a, b, c); the division truncates
  // toward zero, as SystemVerilog does for signed operands.
  function automatic int curve_coord(input int a, input int b, input int c, input int j);
    longint wa, wb, wc, acc;
    wc  = 5 * j * j;
    wb  = (3 * WEIGHT_SCALE) / 4 - 10 * (j - 5) * (j - 5);
    wa  = 5 * (j - 10) * (j - 10);
    acc = wc * c + wb * b + wa * a + WEIGHT_SCALE / 2;
    return int'(acc / WEIGHT_SCALE);
  endfunction

  // Queue the ten segments of one window, walking the pen along the curve
  task automatic plot_window(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy, input logic closes);
    segment_t s;
    int       qx, qy;
    for (int j = 0; j < SEGS_PER_WINDOW; j++) begin
      qx             = curve_coord(ax, bx, cx, j);
      qy             = curve_coord(ay, by, cy, j);
      s.from_x       = COORD_BITS'(pen_x);
      s.from_y       = COORD_BITS'(pen_y);
      s.to_x         = COORD_BITS'(qx);
      s.to_y         = COORD_BITS'(qy);
      s.last_segment = closes && (j == SEGS_PER_WINDOW - 1);
      pending_segments.push_back(s);
      pen_x = qx;
      pen_y = qy;
    end
  endtask

  // Advance the predictor by one accepted control point
  task automatic predict_point(input point_t p);
    int px, py;
    px = int'(p.point_x);
    py = int'(p.point_y);
    if (stroke_held == HELD_NONE) begin
      // Opening point: doubled, so the pen and both window slots start here
      older_x = px; newer_x = px; pen_x = px;
      older_y = py; newer_y = py; pen_y = py;
      if (p.last_point) begin
        plot_window(px, py, px, py, px, py, 1'b1);
      end else begin
        stroke_held = HELD_ONE;
      end
    end else begin
      plot_window(older_x, older_y, newer_x, newer_y, px, py, 1'b0);
      if (p.last_point) begin
        // Closing point is doubled as well: one extra window ends the stroke
        plot_window(newer_x, newer_y, px, py, px, py, 1'b1);
        stroke_held = HELD_NONE;
      end else begin
        stroke_held = HELD_MANY;
      end
      older_x = newer_x; older_y = newer_y;
      newer_x = px;      newer_y = py;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one point; returns just after the edge that accepts it
  task automatic send_point(input point_t p);
    int gap;
    gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point       <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    predict_point(p);
    points_sent++;
    if (p.last_point) strokes_sent++;
  endtask

  // Withdraw valid so the accepted point is not taken twice
  task automatic idle_sender();
    @(negedge clk);
    point_valid <= 1'b0;
  endtask

  // Hold off the sender until every predicted segment has come out
  task automatic wait_for_drain();
    idle_sender();
    while (pending_segments.size() != 0) @(posedge clk);
  endtask

  function automatic point_t make_point(input logic signed [COORD_BITS-1:0] x,
                                        input logic signed [COORD_BITS-1:0] y,
                                        input logic last);
    point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.last_point = last;
    return p;
  endfunction

  // Mostly full-range values, with the extremes and values near zero mixed in
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return COORD_BITS'(int'($urandom_range(16)) - 8);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall, driven at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    seg_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic void report_field(input string name, input int expected,
                                       input int actual);
    if (expected != actual) begin
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected,
                 actual);
    end
  endfunction

  // Compare every accepted segment with the oldest prediction
  always @(posedge clk) begin
    segment_t want;
    if (!rst && seg_valid && !seg_stall) begin
      segments_seen++;
      if (pending_segments.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected segment, expected none, got (%0d,%0d)->(%0d,%0d) last %0b",
                   $time, seg.from_x, seg.from_y, seg.to_x, seg.to_y, seg.last_segment);
      end else begin
        want = pending_segments.pop_front();
        report_field("from_x", int'(want.from_x), int'(seg.from_x));
        report_field("from_y", int'(want.from_y), int'(seg.from_y));
        report_field("to_x", int'(want.to_x), int'(seg.to_x));
        report_field("to_y", int'(want.to_y), int'(seg.to_y));
        report_field("last_segment", int'(want.last_segment), int'(seg.last_segment));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d segments outstanding", $time,
               pending_segments.size());
      $display("quadratic_bspline_segmenter_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Strokes of a single point: one doubled-everywhere window at the corners and the origin
  task automatic test_lone_points();
    send_point(make_point(COORD_MAX, COORD_MAX, 1'b1));
    send_point(make_point(COORD_MIN, COORD_MIN, 1'b1));
    send_point(make_point('0, '0, 1'b1));
    send_point(make_point(COORD_MAX, COORD_MIN, 1'b1));
    idle_sender();
  endtask

  // Two- and three-point strokes spanning the full coordinate range
  task automatic test_short_strokes();
    send_point(make_point(COORD_MIN, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MIN, 1'b1));
    send_point(make_point(COORD_MAX, COORD_MAX, 1'b0));
    send_point(make_point(COORD_MIN, COORD_MIN, 1'b0));
    send_point(make_point(COORD_MAX, COORD_MAX, 1'b1));
    idle_sender();
  endtask

  // Long stroke swinging between extremes; the point count saturates
  task automatic test_long_stroke();
    for (int k = 0; k < 8; k++) begin
      send_point(make_point(k[0] ? COORD_MIN : COORD_MAX, k[1] ? COORD_MAX : COORD_MIN,
                            k == 7));
    end
    idle_sender();
  endtask

  // Reopen after a close, with the sender held off until the block empties
  task automatic test_reopen_after_drain();
    send_point(make_point(16'sd1000, -16'sd1000, 1'b0));
    send_point(make_point(-16'sd1, 16'sd1, 1'b1));
    wait_for_drain();
    send_point(make_point(16'sd3, -16'sd7, 1'b0));
    send_point(make_point(-16'sd500, 16'sd499, 1'b0));
    wait_for_drain();
    send_point(make_point(16'sd12345, -16'sd23456, 1'b1));
    idle_sender();
  endtask

  // Random strokes of mixed length under one idling mix
  task automatic test_random_strokes(input int n_points, input int send_pct,
                                     input int stall_pct);
    int sent, len, pick;
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
    sent = 0;
    while (sent < n_points) begin
      pick = $urandom_range(19);
      if (pick < 3)       len = 1;
      else if (pick < 6)  len = 2;
      else if (pick == 19) len = 24;
      else                len = $urandom_range(3, 8);
      for (int k = 0; k < len; k++)
        send_point(make_point(pick_coord(), pick_coord(), k == len - 1));
      sent += len;
      if ($urandom_range(9) == 0) wait_for_drain();
    end
    idle_sender();
  endtask

  initial begin
    stroke_held = HELD_NONE;
    older_x = 0; older_y = 0; newer_x = 0; newer_y = 0; pen_x = 0; pen_y = 0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_lone_points();
    test_short_strokes();
    test_long_stroke();
    test_reopen_after_drain();

    test_random_strokes(108, 0, 0);
    test_random_strokes(108, 66, 0);
    test_random_strokes(108, 0, 66);
    test_random_strokes(108, 38, 38);

    while (pending_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d strokes of %0d control points, %0d segments checked",
             strokes_sent, points_sent, segments_seen);
    $display("idling mixes: none, sender gaps, receiver stalls, both; %0d failures",
             failures);
    if (failures == 0) begin
      $display("quadratic_bspline_segmenter_unit verification clean");
    end else begin
      $display("quadratic_bspline_segmenter_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/qbs_pkg.sv
rtl/qbs_blend.sv
rtl/quadratic_bspline_segmenter_unit.sv
rtl/qbs_checker.sv
sim/quadratic_bspline_segmenter_unit_test.sv
